### rtl/core/dfl_pkg.sv
// Shared types, constants and helpers for the decimal literal to mantissa block.
// Used by dfl_front, dfl_queue, dfl_back and the top level; no dependencies.
package dfl_pkg;

    localparam int unsigned MANT_W      = 128;
    localparam int unsigned EXP_W       = 32;
    localparam int unsigned SAT_W       = 40;
    localparam int unsigned QUEUE_DEPTH = 4;

    // top word above this stops the mantissa from taking more digits
    localparam logic [31:0] FREEZE_TOP = 32'd429496719;
    // normalization runs until the top word reaches this
    localparam logic [31:0] NORM_TOP   = 32'd214748364;

    localparam logic signed [SAT_W-1:0] I32_MAX_W = 40'sh00_7FFF_FFFF;
    localparam logic signed [SAT_W-1:0] I32_MIN_W = -40'sh00_8000_0000;

    // character codes the parser looks for
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LO  = 8'h65;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_DIGIT,
        ACT_LZFRAC
    } dfl_act_t;

    // one request from the parser to the mantissa engine
    typedef struct packed {
        logic                    fin;        // end of literal after the digit action
        dfl_act_t                act;
        logic [3:0]              digit;
        logic                    frac;       // digit lies in the fraction
        logic signed [EXP_W:0]   exp_field;  // signed exponent field, 33 bits
        logic                    negative;
        logic                    too_many;
    } dfl_cmd_t;

    typedef struct packed {
        logic                    too_many;
        logic                    negative;
        logic signed [EXP_W-1:0] exponent;
        logic [63:0]             mant_low;
        logic [63:0]             mant_high;
    } dfl_result_t;

    function automatic logic signed [EXP_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [EXP_W-1:0] r;
        if (v > I32_MAX_W) begin
            r = I32_MAX_W[EXP_W-1:0];
        end
        else if (v < I32_MIN_W) begin
            r = I32_MIN_W[EXP_W-1:0];
        end
        else begin
            r = v[EXP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [MANT_W-1:0] mul10(input logic [MANT_W-1:0] m);
        return {m[MANT_W-4:0], 3'b000} + {m[MANT_W-2:0], 1'b0};
    endfunction

endpackage

### rtl/core/dfl_queue.sv
// Short request queue between the character parser and the mantissa engine.
// Depends on dfl_pkg (request type, depth).
module dfl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dfl_pkg::dfl_cmd_t wr_cmd,
    input  logic              pop,
    output dfl_pkg::dfl_cmd_t rd_cmd,
    output logic              full,
    output logic              empty
);
    import dfl_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    dfl_cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full   = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### rtl/core/dfl_front.sv
// Character parser: sign, integer/fraction digits, exponent field.
// Depends on dfl_pkg; issues one request per significant event to the queue.
module dfl_front #(
    parameter int unsigned DIGIT_W     = 8,
    parameter int unsigned DIGIT_LIMIT = 254
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              last_char,
    input  logic              queue_full,
    output logic              push,
    output dfl_pkg::dfl_cmd_t cmd
);
    import dfl_pkg::*;

    typedef enum logic [2:0] {
        PH_SIGN,
        PH_MINUS,
        PH_INT,
        PH_FRAC,
        PH_ESIGN,
        PH_EPLUS,
        PH_EDIG,
        PH_IDLE
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic                    lz_reg, lz_next;
    logic [DIGIT_W-1:0]      left_reg, left_next;
    logic signed [EXP_W-1:0] ev_reg, ev_next;
    logic                    en_reg, en_next;

    logic                    accept;
    logic                    is_digit;
    logic                    done;
    logic                    take;
    logic                    take_frac;
    logic                    is_emark;
    dfl_act_t                act;
    logic signed [SAT_W-1:0] ev_wide;
    logic signed [SAT_W-1:0] ev_sum;
    logic signed [EXP_W:0]   ev_ext;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_emark = (char_code == CH_E_UP) || (char_code == CH_E_LO);

    // n*10 + (c - 48) over 40 bits, then saturated
    assign ev_wide = {{(SAT_W-EXP_W){ev_reg[EXP_W-1]}}, ev_reg};
    assign ev_sum  = (ev_wide <<< 3) + (ev_wide <<< 1)
                   + $signed({{(SAT_W-8){1'b0}}, char_code}) - 40'sd48;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        lz_next    = lz_reg;
        left_next  = left_reg;
        ev_next    = ev_reg;
        en_next    = en_reg;
        done       = 1'b0;
        take       = 1'b0;
        take_frac  = 1'b0;
        act        = ACT_NONE;

        if (phase_next == PH_SIGN)
        begin
            phase_next = PH_MINUS;
            done       = (char_code == CH_PLUS);
        end
        if (!done && phase_next == PH_MINUS)
        begin
            phase_next = PH_INT;
            if (char_code == CH_MINUS)
            begin
                neg_next = 1'b1;
                done     = 1'b1;
            end
        end
        if (!done && (phase_next == PH_INT || phase_next == PH_FRAC))
        begin
            if (is_digit && left_reg != '0)
            begin
                take      = 1'b1;
                take_frac = (phase_next == PH_FRAC);
            end
            else if (phase_next == PH_INT && char_code == CH_DOT)
            begin
                phase_next = PH_FRAC;
            end
            else
            begin
                phase_next = is_emark ? PH_ESIGN : PH_IDLE;
            end
            done = 1'b1;
        end
        if (!done && phase_next == PH_ESIGN)
        begin
            phase_next = PH_EPLUS;
            if (char_code == CH_MINUS)
            begin
                en_next = 1'b1;
                done    = 1'b1;
            end
        end
        if (!done && phase_next == PH_EPLUS)
        begin
            phase_next = PH_EDIG;
            done       = (char_code == CH_PLUS);
        end
        if (!done && phase_next == PH_EDIG)
        begin
            ev_next = sat32(ev_sum);
        end

        if (take)
        begin
            if (lz_reg && char_code[3:0] == 4'd0)
            begin
                act = take_frac ? ACT_LZFRAC : ACT_NONE;
            end
            else
            begin
                lz_next   = 1'b0;
                left_next = left_reg - 1'b1;
                act       = ACT_DIGIT;
            end
        end
    end

    assign ev_ext = {ev_next[EXP_W-1], ev_next};

    always_comb
    begin
        cmd.fin       = last_char;
        cmd.act       = act;
        cmd.digit     = char_code[3:0];
        cmd.frac      = take_frac;
        cmd.exp_field = en_next ? -ev_ext : ev_ext;
        cmd.negative  = neg_next;
        cmd.too_many  = (left_next == '0);
    end

    assign push = accept && (act != ACT_NONE || last_char);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIGN;
            neg_reg   <= 1'b0;
            lz_reg    <= 1'b1;
            left_reg  <= DIGIT_W'(DIGIT_LIMIT);
            ev_reg    <= '0;
            en_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                phase_reg <= PH_SIGN;
                neg_reg   <= 1'b0;
                lz_reg    <= 1'b1;
                left_reg  <= DIGIT_W'(DIGIT_LIMIT);
                ev_reg    <= '0;
                en_reg    <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                lz_reg    <= lz_next;
                left_reg  <= left_next;
                ev_reg    <= ev_next;
                en_reg    <= en_next;
            end
        end
    end

endmodule

### rtl/core/dfl_back.sv
// Mantissa engine: takes digit requests, then sums and normalizes at end of literal.
// Depends on dfl_pkg; holds the output register of the result channel.
module dfl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 queue_empty,
    input  dfl_pkg::dfl_cmd_t    cmd,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dfl_pkg::dfl_result_t result
);
    import dfl_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_SUM,
        S_NORM,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [MANT_W-1:0]       mant_reg;
    logic                    frozen_reg;
    logic signed [EXP_W-1:0] exp_run_reg;
    logic signed [EXP_W:0]   fin_exp_reg;
    logic                    fin_neg_reg;
    logic                    fin_tmd_reg;
    logic signed [EXP_W-1:0] x_reg;
    logic                    out_valid_reg;
    dfl_result_t             result_reg;

    logic                    out_load;
    logic                    mant_zero;
    logic [MANT_W-1:0]       mant_x10;
    logic [MANT_W-1:0]       mant_digit;
    logic signed [EXP_W-1:0] exp_inc;
    logic signed [EXP_W-1:0] exp_dec;
    logic signed [EXP_W-1:0] exp_lz;
    logic signed [EXP_W-1:0] x_sum;
    logic signed [EXP_W-1:0] x_dec;

    assign pop       = (state_reg == S_RUN) && !queue_empty;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign mant_zero = (mant_reg == '0);
    assign mant_x10  = mul10(mant_reg);
    assign mant_digit = mant_x10 + {{(MANT_W-4){1'b0}}, cmd.digit};

    // integer digits raise the exponent first, a taken digit lowers it again
    assign exp_inc = cmd.frac ? exp_run_reg
                   : sat32({{(SAT_W-EXP_W){exp_run_reg[EXP_W-1]}}, exp_run_reg} + 40'sd1);
    assign exp_dec = sat32({{(SAT_W-EXP_W){exp_inc[EXP_W-1]}}, exp_inc} - 40'sd1);
    assign exp_lz  = sat32({{(SAT_W-EXP_W){exp_run_reg[EXP_W-1]}}, exp_run_reg} - 40'sd1);
    assign x_sum   = sat32({{(SAT_W-EXP_W){exp_run_reg[EXP_W-1]}}, exp_run_reg}
                         + {{(SAT_W-EXP_W-1){fin_exp_reg[EXP_W]}}, fin_exp_reg});
    assign x_dec   = sat32({{(SAT_W-EXP_W){x_reg[EXP_W-1]}}, x_reg} - 40'sd1);

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            mant_reg      <= '0;
            frozen_reg    <= 1'b0;
            exp_run_reg   <= '0;
            fin_exp_reg   <= '0;
            fin_neg_reg   <= 1'b0;
            fin_tmd_reg   <= 1'b0;
            x_reg         <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_RUN:
                begin
                    if (pop)
                    begin
                        case (cmd.act)
                            ACT_LZFRAC:
                            begin
                                exp_run_reg <= exp_lz;
                            end
                            ACT_DIGIT:
                            begin
                                if (frozen_reg)
                                begin
                                    exp_run_reg <= exp_inc;
                                end
                                else if (mant_reg[MANT_W-1 -: 32] > FREEZE_TOP)
                                begin
                                    exp_run_reg <= exp_inc;
                                    frozen_reg  <= 1'b1;
                                end
                                else
                                begin
                                    mant_reg    <= mant_digit;
                                    exp_run_reg <= exp_dec;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (cmd.fin)
                        begin
                            fin_exp_reg <= cmd.exp_field;
                            fin_neg_reg <= cmd.negative;
                            fin_tmd_reg <= cmd.too_many;
                            state_reg   <= S_SUM;
                        end
                    end
                end
                S_SUM:
                begin
                    if (mant_zero)
                    begin
                        x_reg       <= '0;
                        fin_neg_reg <= 1'b0;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        x_reg     <= x_sum;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (mant_reg[MANT_W-1 -: 32] < NORM_TOP)
                    begin
                        mant_reg <= mant_x10;
                        x_reg    <= x_dec;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        result_reg.mant_high <= mant_reg[MANT_W-1 -: 64];
                        result_reg.mant_low  <= mant_reg[63:0];
                        result_reg.exponent  <= x_reg;
                        result_reg.negative  <= fin_neg_reg;
                        result_reg.too_many  <= fin_tmd_reg;
                        mant_reg             <= '0;
                        frozen_reg           <= 1'b0;
                        exp_run_reg          <= '0;
                        state_reg            <= S_RUN;
                    end
                end
                default:
                begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NORM |-> !mant_zero)
        else $error("normalization entered with a zero mantissa");

    a_out_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (result_reg.mant_high[63:32] >= NORM_TOP)
                     || (result_reg.mant_high == '0 && result_reg.mant_low == '0))
        else $error("result mantissa not normalized");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (result_reg.mant_high != '0) || (result_reg.mant_low != '0)
                     || (result_reg.exponent == '0 && !result_reg.negative))
        else $error("zero result carries sign or exponent");

    a_engine_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> mant_zero && !frozen_reg && exp_run_reg == '0)
        else $error("engine state not cleared after a result");

endmodule

### rtl/core/decimal_float_literal_to_mantissa_top.sv
// Top level of the decimal literal to normalized 128-bit mantissa converter.
// Depends on dfl_pkg, dfl_front, dfl_queue and dfl_back.
//
// Feed a decimal literal one character per request on the s_ side, with s_tlast on
// its final character; one result per literal appears on the m_ side as sign,
// decimal exponent and a 128-bit mantissa normalized so that its top 32 bits are
// at least 214748364 (value = mantissa * 10^exponent). Characters are taken one
// per cycle while the queue is not full: a parser consumes them and posts digit
// requests into a four-entry queue, and the mantissa engine retires one request
// per cycle while it is in its run state. After the last character the engine
// pops its request, sums exponents, then for a nonzero mantissa takes x10 steps
// of normalization (0 to 38, set by how small the mantissa is) until it sees them
// finished, then loads the output register once that register is free. The parser
// keeps accepting characters of the next literal meanwhile until the queue fills.
// A zero value reports exponent 0 and a clear sign; too_many_digits flags a literal
// that used up the digit budget of BUFFER_BYTES - 2 significant digits, after which
// further digits end parsing.
module decimal_float_literal_to_mantissa_top #(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,   // last_char
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // [63:0] mantissa_high, [127:64] mantissa_low,
                                    // [159:128] decimal_exponent, [160] is_negative,
                                    // [161] too_many_digits, [167:162] zero
);
    import dfl_pkg::*;

    localparam int unsigned DIGIT_LIMIT = BUFFER_BYTES - 2;
    localparam int unsigned DIGIT_W     = $clog2(BUFFER_BYTES);

    logic        queue_full;
    logic        queue_empty;
    logic        push;
    logic        pop;
    dfl_cmd_t    wr_cmd;
    dfl_cmd_t    rd_cmd;
    dfl_result_t result;

    dfl_front #(
        .DIGIT_W     (DIGIT_W),
        .DIGIT_LIMIT (DIGIT_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .char_code  (s_tdata),
        .last_char  (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (wr_cmd)
    );

    dfl_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (rd_cmd),
        .full   (queue_full),
        .empty  (queue_empty)
    );

    dfl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .cmd         (rd_cmd),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result      (result)
    );

    // pack the result fields, first field in the low bits
    assign m_tdata = {6'b000000, result.too_many, result.negative, result.exponent,
                      result.mant_low, result.mant_high};

endmodule

### bench/tb_decimal_float_literal_to_mantissa_top.sv
`timescale 1ns / 1ps
// Self-checking bench for decimal_float_literal_to_mantissa_top: streams literals, predicts results.
// Depends on dfl_pkg and the top level; no files, no arguments.
module tb_decimal_float_literal_to_mantissa_top;

    import dfl_pkg::*;

    localparam int BUF_BYTES    = 256;
    localparam int DIGIT_BUDGET = BUF_BYTES - 2;
    localparam int RAND_ITEMS   = 900;
    // margin for the worst-case delay from last char to result, plus queue backlog
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS  = 30;

    // parser position inside a literal
    typedef enum logic [2:0] {
        PS_SIGN,
        PS_MINUS,
        PS_INT,
        PS_FRAC,
        PS_ESIGN,
        PS_EPLUS,
        PS_EDIG,
        PS_SKIP
    } parse_state_t;

    typedef enum logic [1:0] {
        LIT_WELLFORMED,
        LIT_BROKEN,
        LIT_NOISE,
        LIT_LONG
    } lit_kind_t;

    // one directed request; want is used only where typed is set
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        dfl_result_t want;
    } stim_row_t;

    localparam dfl_result_t ZERO_RES = '0;
    // a lone "1" normalizes to 10^38 * 10^-38
    localparam dfl_result_t ONE_RES  = '{too_many: 1'b0, negative: 1'b0,
                                         exponent: -32'sd38,
                                         mant_low: 64'h098A_2240_0000_0000,
                                         mant_high: 64'h4B3B_4CA8_5A86_C47A};

    logic         clk;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;    // [7:0] char_code
    logic         s_tlast  = 1'b0;  // last_char
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;          // [63:0] mantissa_high, [127:64] mantissa_low,
                                    // [159:128] decimal_exponent, [160] is_negative,
                                    // [161] too_many_digits, [167:162] zero

    // ---------------- predictor state ----------------
    parse_state_t pstate;
    bit           lit_negative;
    bit           in_lead_zeros;
    int           exp_running;
    int           exp_field;
    bit           exp_field_neg;
    bit [127:0]   mantissa;
    bit           mant_frozen;
    int           digits_left;

    dfl_result_t  pending_mantissas[$];   // expected results, oldest first
    logic [7:0]   lit_chars[$];           // characters of the literal being built

    int mismatch_count = 0;
    int results_seen   = 0;
    int chars_sent     = 0;
    int literals_sent  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // directed literals: "1", "0", 0xFF, "-0", "+-0.07e-+2", "3x7", "5E<nul>", ".", "-9"
    stim_row_t dir_rows [0:23] = '{
        '{8'h31,          1'b1, 1'b1, ONE_RES},   // first literal after reset
        '{CH_ZERO,        1'b1, 1'b1, ZERO_RES},
        '{8'hFF,          1'b1, 1'b1, ZERO_RES},  // top code, not part of any syntax
        '{CH_MINUS,       1'b0, 1'b0, ZERO_RES},
        '{CH_ZERO,        1'b1, 1'b1, ZERO_RES},  // negative zero reports a clear sign
        '{CH_PLUS,        1'b0, 1'b0, ZERO_RES},
        '{CH_MINUS,       1'b0, 1'b0, ZERO_RES},
        '{CH_ZERO,        1'b0, 1'b0, ZERO_RES},
        '{CH_DOT,         1'b0, 1'b0, ZERO_RES},
        '{CH_ZERO,        1'b0, 1'b0, ZERO_RES},  // fraction leading zero lowers exponent
        '{CH_ZERO + 8'd7, 1'b0, 1'b0, ZERO_RES},
        '{CH_E_LO,        1'b0, 1'b0, ZERO_RES},
        '{CH_MINUS,       1'b0, 1'b0, ZERO_RES},
        '{CH_PLUS,        1'b0, 1'b0, ZERO_RES},
        '{CH_ZERO + 8'd2, 1'b1, 1'b0, ZERO_RES},
        '{CH_ZERO + 8'd3, 1'b0, 1'b0, ZERO_RES},
        '{8'h78,          1'b0, 1'b0, ZERO_RES},  // stray letter ends parsing
        '{CH_ZERO + 8'd7, 1'b1, 1'b0, ZERO_RES},
        '{CH_ZERO + 8'd5, 1'b0, 1'b0, ZERO_RES},
        '{CH_E_UP,        1'b0, 1'b0, ZERO_RES},
        '{8'h00,          1'b1, 1'b0, ZERO_RES},  // exponent takes any code as c - 48
        '{CH_DOT,         1'b1, 1'b1, ZERO_RES},
        '{CH_MINUS,       1'b0, 1'b0, ZERO_RES},
        '{CH_NINE,        1'b1, 1'b0, ZERO_RES}
    };

    decimal_float_literal_to_mantissa_top #(
        .BUFFER_BYTES(BUF_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic int sat_i32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return int'(v);
    endfunction

    function automatic void literal_clear();
        pstate        = PS_SIGN;
        lit_negative  = 1'b0;
        in_lead_zeros = 1'b1;
        exp_running   = 0;
        exp_field     = 0;
        exp_field_neg = 1'b0;
        mantissa      = '0;
        mant_frozen   = 1'b0;
        digits_left   = DIGIT_BUDGET;
    endfunction

    // one digit of the integer or fraction part
    function automatic void literal_digit(input int d, input bit in_frac);
        if (in_lead_zeros && d == 0)
        begin
            if (in_frac)
            begin
                exp_running = sat_i32(longint'(exp_running) - 1);
            end
            return;
        end
        in_lead_zeros = 1'b0;
        digits_left--;
        if (!in_frac)
        begin
            exp_running = sat_i32(longint'(exp_running) + 1);
        end
        if (mant_frozen)
        begin
            return;
        end
        if (mantissa[127:96] > FREEZE_TOP)
        begin
            mant_frozen = 1'b1;
            return;
        end
        mantissa    = mantissa * 128'd10 + 128'(d);
        exp_running = sat_i32(longint'(exp_running) - 1);
    endfunction

    // the ifs fall through on purpose: a sign slot that is not taken passes the char on
    function automatic void literal_take(input logic [7:0] c);
        bit is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (pstate == PS_SIGN)
        begin
            pstate = PS_MINUS;
            if (c == CH_PLUS)
            begin
                return;
            end
        end
        if (pstate == PS_MINUS)
        begin
            pstate = PS_INT;
            if (c == CH_MINUS)
            begin
                lit_negative = 1'b1;
                return;
            end
        end
        if (pstate == PS_INT || pstate == PS_FRAC)
        begin
            if (is_digit && digits_left > 0)
            begin
                literal_digit(int'(c) - int'(CH_ZERO), pstate == PS_FRAC);
            end
            else if (pstate == PS_INT && c == CH_DOT)
            begin
                pstate = PS_FRAC;
            end
            else if (c == CH_E_LO || c == CH_E_UP)
            begin
                pstate = PS_ESIGN;
            end
            else
            begin
                pstate = PS_SKIP;
            end
            return;
        end
        if (pstate == PS_ESIGN)
        begin
            pstate = PS_EPLUS;
            if (c == CH_MINUS)
            begin
                exp_field_neg = 1'b1;
                return;
            end
        end
        if (pstate == PS_EPLUS)
        begin
            pstate = PS_EDIG;
            if (c == CH_PLUS)
            begin
                return;
            end
        end
        if (pstate == PS_EDIG)
        begin
            exp_field = sat_i32(longint'(exp_field) * 10 + longint'(c) - longint'(CH_ZERO));
        end
    endfunction

    // normalize and build the result of the finished literal, then start over
    function automatic dfl_result_t literal_close();
        longint      e;
        int          x;
        bit          sgn;
        dfl_result_t r;
        e   = exp_field_neg ? -longint'(exp_field) : longint'(exp_field);
        x   = sat_i32(longint'(exp_running) + e);
        sgn = lit_negative;
        if (mantissa == '0)
        begin
            x   = 0;
            sgn = 1'b0;
        end
        else
        begin
            while (mantissa[127:96] < NORM_TOP)
            begin
                mantissa = mantissa * 128'd10;
                x        = sat_i32(longint'(x) - 1);
            end
        end
        r.mant_high = mantissa[127:64];
        r.mant_low  = mantissa[63:0];
        r.exponent  = x;
        r.negative  = sgn;
        r.too_many  = (digits_left == 0);
        literal_clear();
        return r;
    endfunction

    // ---------------- literal builders ----------------

    function automatic void push_digits(input int n, input bit zeros_only);
        repeat (n)
        begin
            lit_chars.push_back(zeros_only ? CH_ZERO : CH_ZERO + 8'($urandom_range(9)));
        end
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return 0;
        end
        if (r < 75)
        begin
            return $urandom_range(1, 9);
        end
        if (r < 93)
        begin
            return $urandom_range(10, 24);
        end
        return $urandom_range(25, 48);   // at the top of this range long enough to freeze the mantissa
    endfunction

    function automatic void fill_wellformed(input int n_int);
        int n_exp;
        if ($urandom_range(3) == 0)
        begin
            lit_chars.push_back(CH_PLUS);
        end
        if ($urandom_range(2) == 0)
        begin
            lit_chars.push_back(CH_MINUS);
        end
        if ($urandom_range(3) == 0)
        begin
            push_digits($urandom_range(1, 4), 1'b1);
        end
        push_digits(n_int, 1'b0);
        if ($urandom_range(1) == 1)
        begin
            lit_chars.push_back(CH_DOT);
            if ($urandom_range(2) == 0)
            begin
                push_digits($urandom_range(1, 8), 1'b1);
            end
            push_digits(pick_count(), 1'b0);
        end
        if ($urandom_range(1) == 1)
        begin
            lit_chars.push_back($urandom_range(1) == 1 ? CH_E_UP : CH_E_LO);
            if ($urandom_range(2) == 0)
            begin
                lit_chars.push_back(CH_MINUS);
            end
            if ($urandom_range(2) == 0)
            begin
                lit_chars.push_back(CH_PLUS);
            end
            // now and then enough digits to saturate the exponent
            n_exp = ($urandom_range(9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 3);
            push_digits(n_exp, 1'b0);
            if ($urandom_range(7) == 0)
            begin
                lit_chars.push_back(8'($urandom_range(255)));
            end
        end
        if (lit_chars.size() == 0)
        begin
            lit_chars.push_back(CH_ZERO);
        end
    endfunction

    function automatic void build_literal(input lit_kind_t kind);
        int pos;
        lit_chars.delete();
        case (kind)
            LIT_NOISE:
            begin
                repeat ($urandom_range(1, 8))
                begin
                    lit_chars.push_back(8'($urandom_range(255)));
                end
            end
            LIT_LONG:
            begin
                // runs near or past the digit budget
                fill_wellformed($urandom_range(250, 262));
            end
            LIT_BROKEN:
            begin
                fill_wellformed(pick_count());
                pos = $urandom_range(lit_chars.size() - 1);
                if ($urandom_range(1) == 1)
                begin
                    lit_chars[pos] = 8'($urandom_range(255));
                end
                else
                begin
                    lit_chars.insert(pos, 8'($urandom_range(255)));
                end
            end
            default:
            begin
                fill_wellformed(pick_count());
            end
        endcase
    endfunction

    // ---------------- stimulus and checking ----------------

    task automatic flag_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("%0t mismatch at result %0d: %s got %h want %h",
                     $realtime, results_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    // one character request; the prediction advances once the block takes it
    task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                             input dfl_result_t want);
        bit          took;
        dfl_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        // ready is sampled mid-cycle where it is stable; the transfer lands on the next edge
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        chars_sent++;
        literal_take(c);
        if (last)
        begin
            predicted = literal_close();
            pending_mantissas.push_back(typed ? want : predicted);
            literals_sent++;
        end
    endtask

    task automatic check_result(input logic [167:0] word);
        dfl_result_t got;
        dfl_result_t want;
        got = dfl_result_t'(word[161:0]);
        results_seen++;
        if (pending_mantissas.size() == 0)
        begin
            flag_mismatch("result with nothing pending", word[127:0], '0);
            return;
        end
        want = pending_mantissas.pop_front();
        if (got.mant_high !== want.mant_high)
        begin
            flag_mismatch("mantissa_high", got.mant_high, want.mant_high);
        end
        if (got.mant_low !== want.mant_low)
        begin
            flag_mismatch("mantissa_low", got.mant_low, want.mant_low);
        end
        if (got.exponent !== want.exponent)
        begin
            flag_mismatch("decimal_exponent", got.exponent, want.exponent);
        end
        if (got.negative !== want.negative)
        begin
            flag_mismatch("is_negative", got.negative, want.negative);
        end
        if (got.too_many !== want.too_many)
        begin
            flag_mismatch("too_many_digits", got.too_many, want.too_many);
        end
        if (word[167:162] !== '0)
        begin
            flag_mismatch("pad bits", word[167:162], '0);
        end
    endtask

    // receiver: random backpressure per the current mix
    initial
    begin
        forever
        begin
            @(posedge clk);
            m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor, mid-cycle so outputs and ready have settled
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                check_result(m_tdata);
            end
        end
    end

    // hard stop
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results pending", pending_mantissas.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int        rand_chars;
        int        lit_idx;
        int        mix;
        int        cur_mix;
        lit_kind_t kind;
        int        r;
        literal_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < 24; i++)
        begin
            send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        end

        // random literals, one idle mix per quarter; drain between mixes
        rand_chars = 0;
        lit_idx    = 0;
        cur_mix    = -1;
        while (rand_chars < RAND_ITEMS || cur_mix < 3)
        begin
            mix = (rand_chars * 4) / RAND_ITEMS;
            // step through every mix even when a long literal jumps ahead
            if (mix > cur_mix + 1)
            begin
                mix = cur_mix + 1;
            end
            if (mix != cur_mix)
            begin
                s_tvalid <= 1'b0;
                while (pending_mantissas.size() != 0)
                begin
                    @(posedge clk);
                end
                cur_mix = mix;
                case (mix)
                    0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                    default: begin send_idle_pct = 24; recv_stall_pct = 24; end
                endcase
            end
            r = $urandom_range(99);
            if (lit_idx == 3 || lit_idx == 60 || r == 0)
            begin
                kind = LIT_LONG;
            end
            else if (r < 72)
            begin
                kind = LIT_WELLFORMED;
            end
            else if (r < 88)
            begin
                kind = LIT_BROKEN;
            end
            else
            begin
                kind = LIT_NOISE;
            end
            build_literal(kind);
            for (int k = 0; k < lit_chars.size(); k++)
            begin
                send_char(lit_chars[k], k == lit_chars.size() - 1, 1'b0, ZERO_RES);
            end
            rand_chars += lit_chars.size();
            lit_idx++;
        end

        s_tvalid <= 1'b0;
        while (pending_mantissas.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d characters in %0d literals, %0d results compared",
                 chars_sent, literals_sent, results_seen);
        $display("mixes: free flow, sender gaps, receiver stalls, both; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
